// File: rtl/fstm_pkg.sv
// Shared types, command codes and geometry constants of the flat span texture mapper.
package fstm_pkg;

    // Texture geometry: a 64x64 flat of bytes, addressed as row * 64 + column.
    localparam int TEX_SIDE_W   = 6;
    localparam int TEX_ADDR_W   = 2 * TEX_SIDE_W;
    localparam int TEXEL_W      = 8;
    localparam int SHADE_ADDR_W = 8;
    localparam int COLOR_W      = 32;
    localparam int COORD_W      = 32;
    localparam int COUNT_W      = 7;
    localparam int CMD_W        = 2;

    // Longest span chunk accepted; longer counts are clipped to this.
    localparam int MAX_RUN = 64;

    // Lowest coordinate bit that still selects a texel row or column.
    localparam int COORD_SEL_LSB = COORD_W - TEX_SIDE_W;

    // Packed width of the slave-side data, rounded up to whole bytes.
    localparam int IN_FIELDS_W = TEX_ADDR_W + COLOR_W + 4 * COORD_W + COUNT_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // Command codes carried in tuser.
    localparam logic [CMD_W-1:0] CMD_WRITE_TEXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_SHADE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW_SPAN   = 2'd2;

    // Pixel request from the span sequencer to the texture memory stage.
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [TEX_ADDR_W-1:0] addr;
    } pix_req_t;

    // Texel fetched for one pixel, on its way to the shade table.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [TEXEL_W-1:0] texel;
    } texel_stage_t;

    // Write port of the texture memory.
    typedef struct packed {
        logic                  en;
        logic [TEX_ADDR_W-1:0] addr;
        logic [TEXEL_W-1:0]    data;
    } tex_wr_t;

    // Write port of the shade table.
    typedef struct packed {
        logic                    en;
        logic [SHADE_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]      data;
    } shade_wr_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] remaining;
    } seq_status_t;

endpackage

// File: rtl/flat_span_texture_mapper.sv
// Order: a write takes effect at its transfer; the first pixel of a span passes the texture
// read register and then the shade table read register before it is offered.
// Throughput: one pixel per cycle while the output takes them, set by the single read port
// of each memory; a draw of n pixels (n up to 64) holds the input off until its last pixel
// has left the texture read register. Writes and empty draws do not hold the input off.
// Reset: rst_n clears the sequencer busy flag and count and the stage valid bits; memories stay as written.
module flat_span_texture_mapper
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: entry_index[11:0], entry_value[31:0], u_position[31:0],
    // v_position[31:0], u_increment[31:0], v_increment[31:0], pixel_count[6:0], zero fill.
    input  logic [fstm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [fstm_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: pixel_color[31:0].
    output logic [fstm_pkg::COLOR_W-1:0]     m_axis_tdata,
    output logic                             m_axis_tlast
);
    import fstm_pkg::*;

    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + TEX_ADDR_W;
    localparam int U_LSB     = VAL_LSB + COLOR_W;
    localparam int V_LSB     = U_LSB + COORD_W;
    localparam int DU_LSB    = V_LSB + COORD_W;
    localparam int DV_LSB    = DU_LSB + COORD_W;
    localparam int COUNT_LSB = DV_LSB + COORD_W;

    logic [TEX_ADDR_W-1:0] entry_index;
    logic [COLOR_W-1:0]    entry_value;
    logic [COORD_W-1:0]    u_position;
    logic [COORD_W-1:0]    v_position;
    logic [COORD_W-1:0]    u_increment;
    logic [COORD_W-1:0]    v_increment;
    logic [COUNT_W-1:0]    pixel_count;
    logic                  in_xfer;
    logic                  start;
    logic                  advance;

    pix_req_t     req;
    seq_status_t  status;
    texel_stage_t texel_stage;
    tex_wr_t      tex_wr;
    shade_wr_t    shade_wr;

    // Unpack the slave-side fields.
    assign entry_index = s_axis_tdata[IDX_LSB +: TEX_ADDR_W];
    assign entry_value = s_axis_tdata[VAL_LSB +: COLOR_W];
    assign u_position  = s_axis_tdata[U_LSB +: COORD_W];
    assign v_position  = s_axis_tdata[V_LSB +: COORD_W];
    assign u_increment = s_axis_tdata[DU_LSB +: COORD_W];
    assign v_increment = s_axis_tdata[DV_LSB +: COORD_W];
    assign pixel_count = s_axis_tdata[COUNT_LSB +: COUNT_W];

    // One item at a time: no span being issued and no texel awaiting its lookup.
    assign s_axis_tready = !status.busy && !texel_stage.valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign start         = in_xfer && (s_axis_tuser == CMD_DRAW_SPAN);

    // The whole pixel pipeline moves whenever the output register is empty or its pixel is being taken.
    assign advance = !m_axis_tvalid || m_axis_tready;

    // Decode write commands onto the memory write ports.
    assign tex_wr.en     = in_xfer && (s_axis_tuser == CMD_WRITE_TEXEL);
    assign tex_wr.addr   = entry_index;
    assign tex_wr.data   = entry_value[TEXEL_W-1:0];
    assign shade_wr.en   = in_xfer && (s_axis_tuser == CMD_WRITE_SHADE)
                           && (entry_index[TEX_ADDR_W-1:SHADE_ADDR_W] == '0);
    assign shade_wr.addr = entry_index[SHADE_ADDR_W-1:0];
    assign shade_wr.data = entry_value;

    fstm_span_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .u_position  (u_position),
        .v_position  (v_position),
        .u_increment (u_increment),
        .v_increment (v_increment),
        .pixel_count (pixel_count),
        .advance     (advance),
        .req         (req),
        .status      (status)
    );

    fstm_texel_mem u_texel
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .wr      (tex_wr),
        .req     (req),
        .stage   (texel_stage)
    );

    fstm_shade_mem u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .wr        (shade_wr),
        .stage     (texel_stage),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_color (m_axis_tdata)
    );

    // A draw with a non-zero count must leave the sequencer busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && (pixel_count != '0) |=> status.busy)
        else $error("draw transfer did not start the sequencer");

    // While the output stalls, the sequencer must not lose a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.busy && !advance |=> status.busy && $stable(status.remaining))
        else $error("sequencer stepped during a stall");

    // A write must never reach a memory while a span still reads it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tex_wr.en || shade_wr.en) |-> !status.busy && !texel_stage.valid)
        else $error("memory write overlapped a span read");

    // The sequencer never holds more than one run of pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> (status.remaining != '0) && (status.remaining <= COUNT_W'(MAX_RUN)))
        else $error("sequencer pixel count out of range");

endmodule

// File: rtl/fstm_span_seq.sv
// Span sequencer: steps u and v across a span and issues one texel address per pixel.
module fstm_span_seq
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fstm_pkg::COORD_W-1:0] u_position,
    input  logic [fstm_pkg::COORD_W-1:0] v_position,
    input  logic [fstm_pkg::COORD_W-1:0] u_increment,
    input  logic [fstm_pkg::COORD_W-1:0] v_increment,
    input  logic [fstm_pkg::COUNT_W-1:0] pixel_count,
    input  logic                         advance,
    output fstm_pkg::pix_req_t           req,
    output fstm_pkg::seq_status_t        status
);
    import fstm_pkg::*;

    logic [COORD_W-1:0] u_reg, u_next;
    logic [COORD_W-1:0] v_reg, v_next;
    logic [COORD_W-1:0] du_reg, du_next;
    logic [COORD_W-1:0] dv_reg, dv_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic               busy_reg, busy_next;
    logic [COUNT_W-1:0] count_sat;
    logic               issue;

    // Clip the count to the longest run; a zero count starts nothing.
    assign count_sat = (pixel_count > COUNT_W'(MAX_RUN)) ? COUNT_W'(MAX_RUN) : pixel_count;
    assign issue     = busy_reg && advance;

    // Load a new span, or step to the next pixel when one has been issued.
    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        du_next   = du_reg;
        dv_next   = dv_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        if (start)
        begin
            u_next    = u_position;
            v_next    = v_position;
            du_next   = u_increment;
            dv_next   = v_increment;
            rem_next  = count_sat;
            busy_next = (count_sat != '0);
        end
        else if (issue)
        begin
            u_next    = u_reg + du_reg;
            v_next    = v_reg + dv_reg;
            rem_next  = rem_reg - COUNT_W'(1);
            busy_next = (rem_reg != COUNT_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

    // Coordinate and step registers need no reset.
    always_ff @(posedge clk)
    begin
        u_reg  <= u_next;
        v_reg  <= v_next;
        du_reg <= du_next;
        dv_reg <= dv_next;
    end

    // The texel address is the top six bits of v above the top six bits of u.
    assign req.valid = busy_reg;
    assign req.last  = (rem_reg == COUNT_W'(1));
    assign req.addr  = {v_reg[COORD_W-1:COORD_SEL_LSB], u_reg[COORD_W-1:COORD_SEL_LSB]};

    assign status.busy      = busy_reg;
    assign status.remaining = rem_reg;

endmodule

// File: rtl/fstm_texel_mem.sv
// Texture memory stage: 4096 x 8 flat storage with a registered read per pixel.
module fstm_texel_mem
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  fstm_pkg::tex_wr_t      wr,
    input  fstm_pkg::pix_req_t     req,
    output fstm_pkg::texel_stage_t stage
);
    import fstm_pkg::*;

    localparam int TEX_DEPTH = 1 << TEX_ADDR_W;

    logic [TEXEL_W-1:0] tex_mem [TEX_DEPTH];
    logic [TEXEL_W-1:0] texel_reg;
    logic               valid_reg;
    logic               last_reg;

    // Write port; reads happen only while no write can be accepted.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tex_mem[wr.addr] <= wr.data;
        end
    end

    // Registered read, held while the output side stalls.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            texel_reg <= tex_mem[req.addr];
            last_reg  <= req.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= req.valid;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.last  = last_reg;
    assign stage.texel = texel_reg;

endmodule

// File: rtl/fstm_shade_mem.sv
// Shade table stage: 256 x 32 ARGB colours, its registered read forms the output register.
module fstm_shade_mem
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  fstm_pkg::shade_wr_t          wr,
    input  fstm_pkg::texel_stage_t       stage,
    output logic                         out_valid,
    output logic                         out_last,
    output logic [fstm_pkg::COLOR_W-1:0] out_color
);
    import fstm_pkg::*;

    localparam int SHADE_DEPTH = 1 << SHADE_ADDR_W;

    logic [COLOR_W-1:0] shade_mem [SHADE_DEPTH];
    logic [COLOR_W-1:0] color_reg;
    logic               valid_reg;
    logic               last_reg;

    // Write port; no texel is waiting for a lookup when a write is accepted.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            shade_mem[wr.addr] <= wr.data;
        end
    end

    // Look the texel up; the result holds until the transfer completes.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            color_reg <= shade_mem[stage.texel];
            last_reg  <= stage.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage.valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign out_color = color_reg;

endmodule

// File: sim/fstm_span_checker.sv
`timescale 1ns / 100ps
// Span checker: predicts the shaded pixels of each draw and compares them with the pixel stream.
module fstm_span_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // Fields from bit 0: entry_index[11:0], entry_value[31:0], u_position[31:0],
    // v_position[31:0], u_increment[31:0], v_increment[31:0], pixel_count[6:0], zero fill.
    input  logic [fstm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [fstm_pkg::CMD_W-1:0]     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: pixel_color[31:0].
    input  logic [fstm_pkg::COLOR_W-1:0]   m_axis_tdata,
    input  logic                           m_axis_tlast,
    output int                             fail_count,
    output int                             pending
);
    import fstm_pkg::*;

    // Bit positions of the fields within the slave-side data.
    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + TEX_ADDR_W;
    localparam int U_LSB   = VAL_LSB + COLOR_W;
    localparam int V_LSB   = U_LSB + COORD_W;
    localparam int DU_LSB  = V_LSB + COORD_W;
    localparam int DV_LSB  = DU_LSB + COORD_W;
    localparam int CNT_LSB = DV_LSB + COORD_W;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last;
    } shaded_pixel_t;

    // Private copy of the two memories.
    logic [TEXEL_W-1:0] texels [0:(1 << TEX_ADDR_W)-1];
    logic [COLOR_W-1:0] shades [0:(1 << SHADE_ADDR_W)-1];

    shaded_pixel_t shaded_pixels [$];
    shaded_pixel_t oldest;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Applies one command to the memory copy and queues the pixels a draw produces.
    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
        logic [TEX_ADDR_W-1:0] index;
        logic [COLOR_W-1:0]    value;
        logic [COORD_W-1:0]    u;
        logic [COORD_W-1:0]    v;
        logic [COORD_W-1:0]    du;
        logic [COORD_W-1:0]    dv;
        logic [COUNT_W-1:0]    count;
        int                    run;
        int                    k;
        shaded_pixel_t         pix;
        index = data[IDX_LSB +: TEX_ADDR_W];
        value = data[VAL_LSB +: COLOR_W];
        u     = data[U_LSB +: COORD_W];
        v     = data[V_LSB +: COORD_W];
        du    = data[DU_LSB +: COORD_W];
        dv    = data[DV_LSB +: COORD_W];
        count = data[CNT_LSB +: COUNT_W];
        case (cmd)
            CMD_WRITE_TEXEL:
                texels[index] = value[TEXEL_W-1:0];
            CMD_WRITE_SHADE:
                // Indexes beyond the table are dropped.
                if (index < (1 << SHADE_ADDR_W))
                    shades[index[SHADE_ADDR_W-1:0]] = value;
            CMD_DRAW_SPAN:
            begin
                run = (count > MAX_RUN) ? MAX_RUN : int'(count);
                for (k = 0; k < run; k++)
                begin
                    pix.color = shades[texels[{v[COORD_W-1 -: TEX_SIDE_W],
                                               u[COORD_W-1 -: TEX_SIDE_W]}]];
                    pix.last  = (k == run - 1);
                    shaded_pixels.push_back(pix);
                    u = u + du;
                    v = v + dv;
                end
            end
            default:
                ;
        endcase
    endtask

    // Results are checked before the input of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (shaded_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: pixel transfer with none expected, got color %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    oldest = shaded_pixels.pop_front();
                    if (m_axis_tdata !== oldest.color)
                    begin
                        fail_count++;
                        $display("%0t ns: pixel_color mismatch, expected %h, got %h",
                                 $time, oldest.color, m_axis_tdata);
                    end
                    if (m_axis_tlast !== oldest.last)
                    begin
                        fail_count++;
                        $display("%0t ns: last_pixel mismatch, expected %b, got %b",
                                 $time, oldest.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tuser, s_axis_tdata);
            pending = shaded_pixels.size();
        end
    end

endmodule

// File: sim/tb_flat_span_texture_mapper.sv
`timescale 1ns / 100ps
// Testbench top: drives commands and the pixel sink of the span texture mapper and reports.
module tb_flat_span_texture_mapper;
    import fstm_pkg::*;

    localparam int              CLK_PERIOD     = 20;
    localparam longint          TIMEOUT_CYCLES = 1000000;
    localparam int              HOLD_CYCLES    = 300;
    localparam int              DRAIN_CYCLES   = 12;
    localparam int              PHASE_ITEMS    = 15;
    localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
    localparam logic [COORD_W-1:0] ONE_TEXEL   = 32'h0400_0000;
    // Coordinates up to this bound stay in texel row 0.
    localparam logic [COORD_W-1:0] ROW0_MASK   = 32'h03FF_FFFF;
    // Largest row step drawn; a full run with it still stays inside row 0.
    localparam logic [COORD_W-1:0] ROW_STEP_MAX = 32'h0010_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [COLOR_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;

    int fail_count;
    int pending;

    // Phase controls shared by the sender and the receiver.
    bit calm = 1'b1;
    bit pressure_req = 1'b0;
    bit pressure_done = 1'b0;

    flat_span_texture_mapper dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    fstm_span_checker span_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Packs the command fields, lowest field first, with the fill bits left at zero.
    function automatic logic [IN_DATA_W-1:0] pack_item(
        input logic [TEX_ADDR_W-1:0] index,
        input logic [COLOR_W-1:0]    value,
        input logic [COORD_W-1:0]    u,
        input logic [COORD_W-1:0]    v,
        input logic [COORD_W-1:0]    du,
        input logic [COORD_W-1:0]    dv,
        input logic [COUNT_W-1:0]    count);
        pack_item = '0;
        pack_item[IN_FIELDS_W-1:0] = {count, dv, du, v, u, value, index};
    endfunction

    // Per-pixel step: anything at all, or a short stride forwards or backwards.
    function automatic logic [COORD_W-1:0] rand_step();
        case ($urandom_range(2, 0))
            0:       rand_step = $urandom;
            1:       rand_step = $urandom_range(32'h0800_0000, 0);
            default: rand_step = 32'd0 - $urandom_range(32'h0800_0000, 0);
        endcase
    endfunction

    // Pixel count: mostly short spans, some long, a few empty or clipped.
    function automatic logic [COUNT_W-1:0] rand_count();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick < 6)
            rand_count = COUNT_W'($urandom_range(8, 1));
        else if (pick < 9)
            rand_count = COUNT_W'($urandom_range(MAX_RUN, 9));
        else if ($urandom_range(1, 0) == 0)
            rand_count = '0;
        else
            rand_count = COUNT_W'($urandom_range(127, MAX_RUN + 1));
    endfunction

    // Texel write value: noise above a byte that names one of the loaded shade entries.
    function automatic logic [COLOR_W-1:0] rand_texel();
        logic [TEXEL_W-1:0] shade_sel;
        shade_sel = TEXEL_W'($urandom_range(7, 0));
        if ($urandom_range(1, 0) == 1)
            shade_sel = shade_sel | 8'hF8;
        rand_texel = ($urandom & 32'hFFFF_FF00) | {24'd0, shade_sel};
    endfunction

    // Offers one command, after a random gap outside calm phases, and returns at the falling edge after its transfer.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
        int idle;
        idle = calm ? 0 : $urandom_range(15, 0);
        if (idle > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Write-style command; the coordinate fields carry noise.
    task automatic send_write(input logic [CMD_W-1:0] cmd, input logic [TEX_ADDR_W-1:0] index,
                              input logic [COLOR_W-1:0] value);
        send_item(cmd, pack_item(index, value, $urandom, $urandom, $urandom, $urandom,
                                 COUNT_W'($urandom)));
    endtask

    // Draw command; the write fields carry noise.
    task automatic send_draw(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                             input logic [COORD_W-1:0] du, input logic [COORD_W-1:0] dv,
                             input logic [COUNT_W-1:0] count);
        send_item(CMD_DRAW_SPAN, pack_item(TEX_ADDR_W'($urandom), $urandom, u, v, du, dv,
                                           count));
    endtask

    // Pixel sink: random stalls per transfer outside calm phases, and one long hold-off when asked.
    initial
    begin : pixel_sink
        int idle;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_done)
            begin
                pressure_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            idle = calm ? 0 : $urandom_range(15, 0);
            if (idle > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (idle) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_flat_span_texture_mapper failed");
        $finish;
    end

    // Command stimulus and verdict.
    initial
    begin : stimulus
        int          i;
        int          phase;
        int          n;
        int          pick;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] dv;
        logic [31:0] m;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Load the shade entries that texels may name, then the whole of texel row 0.
        // Every later draw stays in row 0, or on the corner texel once it is written.
        calm = 1'b1;
        for (i = 0; i < 8; i++)
        begin
            send_write(CMD_WRITE_SHADE, TEX_ADDR_W'(i), $urandom);
            send_write(CMD_WRITE_SHADE, TEX_ADDR_W'(i + 248), $urandom);
        end
        for (i = 0; i < (1 << TEX_SIDE_W); i++)
            send_write(CMD_WRITE_TEXEL, TEX_ADDR_W'(i), rand_texel());

        // Directed part: field extremes, ignored commands and clipped counts.
        calm = 1'b0;
        send_write(CMD_WRITE_SHADE, 12'd255, 32'hFFFF_FFFF);
        send_write(CMD_WRITE_SHADE, 12'd0, 32'h0000_0000);
        send_write(CMD_WRITE_TEXEL, 12'd4095, 32'hFFFF_FFFF);
        send_write(CMD_WRITE_TEXEL, 12'd0, 32'hFFFF_FF00);
        send_write(CMD_WRITE_SHADE, 12'd256, 32'hDEAD_BEEF);
        send_write(CMD_WRITE_SHADE, 12'd4095, 32'h0000_0000);
        send_item(CMD_UNUSED, pack_item('1, '1, '1, '1, '1, '1, '1));
        send_draw(32'h0, 32'h0, 32'h0, 32'h0, 7'd1);
        send_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64);
        send_draw($urandom, $urandom, ONE_TEXEL, ONE_TEXEL, 7'd0);
        send_draw($urandom, $urandom & ROW0_MASK, ONE_TEXEL, 32'h0, 7'd127);
        send_draw($urandom, $urandom & ROW0_MASK, rand_step(), 32'h0, 7'd65);
        send_draw(32'hFC00_0000, 32'hFC00_0000, 32'h0, 32'h0, 7'd2);
        send_draw($urandom, $urandom & ROW0_MASK, 32'hFFFF_FFFF, 32'h0, 7'd64);

        // Writes straight after and straight before draws that depend on them.
        calm = 1'b1;
        send_draw(32'h0, 32'h0, 32'h0, 32'h0, 7'd3);
        send_write(CMD_WRITE_SHADE, 12'd0, 32'h1234_5678);
        send_draw(32'h0, 32'h0, 32'h0, 32'h0, 7'd1);
        send_write(CMD_WRITE_TEXEL, 12'd0, 32'h0000_00FF);
        send_draw(32'h0, 32'h0, 32'h0, 32'h0, 7'd2);
        send_write(CMD_WRITE_SHADE, 12'd255, 32'h8765_4321);
        send_draw(32'h0, 32'h0, ONE_TEXEL, 32'h0, 7'd4);

        // Random part in four phases; the first also holds the sink off for a long stretch.
        for (phase = 0; phase < 4; phase++)
        begin
            calm = (phase == 2);
            if (phase == 0)
                pressure_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                begin
                    // Any column walk; the row walk is kept short enough to stay in row 0.
                    u = $urandom;
                    m = $urandom_range(ROW_STEP_MAX, 0);
                    if ($urandom_range(1, 0) == 0)
                    begin
                        dv = m;
                        v  = $urandom_range(ROW0_MASK - 63 * m, 0);
                    end
                    else
                    begin
                        dv = 32'd0 - m;
                        v  = $urandom_range(ROW0_MASK, 63 * m);
                    end
                    send_draw(u, v, rand_step(), dv, rand_count());
                end
                else if (pick < 82)
                    send_write(CMD_WRITE_TEXEL, TEX_ADDR_W'($urandom_range(4095, 0)),
                               rand_texel());
                else if (pick < 92)
                    send_write(CMD_WRITE_SHADE, TEX_ADDR_W'($urandom_range(255, 0)), $urandom);
                else if (pick < 96)
                    send_write(CMD_WRITE_SHADE, TEX_ADDR_W'($urandom_range(4095, 256)),
                               $urandom);
                else
                    send_write(CMD_UNUSED, TEX_ADDR_W'($urandom_range(4095, 0)), $urandom);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain the remaining pixels, then allow for the pipeline depth.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_flat_span_texture_mapper passed");
        else
            $display("tb_flat_span_texture_mapper failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fstm_pkg.sv
rtl/fstm_span_seq.sv
rtl/fstm_texel_mem.sv
rtl/fstm_shade_mem.sv
rtl/flat_span_texture_mapper.sv
sim/fstm_span_checker.sv
sim/tb_flat_span_texture_mapper.sv
